>>> rtl/gcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_pkg: shared definitions for the great-circle distance block
// Fixed-point constants, the CORDIC arctangent table and the queue word.
// ----------------------------------------------------------------------------
package gcd_pkg;

  localparam int GCD_ANGLE_FRAC      = 20;
  localparam int GCD_CORDIC_STAGES   = 24;
  localparam int GCD_FIFO_DEPTH      = 4;
  localparam int GCD_DEG_QUARTER     = 90;
  localparam int GCD_DEG_HALF        = 180;
  localparam int GCD_EARTH_RADIUS_KM = 6371;

  localparam logic [22:0] GCD_RADIUS_M = 23'(GCD_EARTH_RADIUS_KM * 1000);
  localparam logic [24:0] GCD_MAX_DIST = 25'd20015087;

  // Angle magnitudes are carried in degrees with 28 fraction bits.
  localparam int GCD_MAG_W  = 36;
  localparam int GCD_TRIG_W = 34;

  localparam logic [27:0] GCD_PI_Q26      = 28'd210828714;
  localparam logic [31:0] GCD_PI_Q30      = 32'd3373259426;
  localparam logic [31:0] GCD_HALF_PI_Q30 = 32'd1686629713;
  localparam logic [63:0] GCD_GAIN_Q30    = 64'd652032874;
  localparam logic [63:0] GCD_ONE_Q60     = 64'd1 << 60;

  // The degree-to-radian divisor 180 * 2^24 is split into 45 * 2^26.
  localparam int          GCD_D2R_SHIFT = 26;
  localparam int          GCD_D2R_ODD   = GCD_DEG_HALF / 4;
  localparam logic [63:0] GCD_D2R_HALF  = 64'(GCD_DEG_HALF) << 23;

  // Division by the odd part is a multiplication by its rounded-up
  // reciprocal; the result is exact for dividends below 2^38.
  localparam int          GCD_D2R_N_W   = 38;
  localparam int          GCD_D2R_RSH   = 44;
  localparam logic [38:0] GCD_D2R_RECIP =
    39'(((64'd1 << GCD_D2R_RSH) / 64'(GCD_D2R_ODD)) + 64'd1);

  localparam int GCD_ROT_PRE       = 5;
  localparam int GCD_ISQRT_STAGES  = 31;

  localparam logic [31:0] GCD_ATAN_Q30 [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
    32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
    32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
    32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
    32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000007,
    32'h00000003, 32'h00000001, 32'h00000000, 32'h00000000
  };

  typedef struct packed {
    logic [GCD_MAG_W-1:0] colat_a;
    logic [GCD_MAG_W-1:0] colat_b;
    logic [GCD_MAG_W-1:0] dlon;
  } gcd_item_t;

endpackage

>>> rtl/gcd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_front: input stage
// Clamps the coordinates, forms colatitudes and the folded longitude gap.
// ----------------------------------------------------------------------------
module gcd_front
  import gcd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [27:0]  in_lat_a,
  input  logic signed [28:0]  in_lon_a,
  input  logic signed [27:0]  in_lat_b,
  input  logic signed [28:0]  in_lon_b,
  input  logic                q_full,
  output logic                q_push,
  output gcd_item_t           q_item
);

  localparam logic signed [39:0] S90  = 40'(GCD_DEG_QUARTER) <<< GCD_ANGLE_FRAC;
  localparam logic signed [39:0] S180 = 40'(GCD_DEG_HALF) <<< GCD_ANGLE_FRAC;
  localparam logic signed [39:0] S360 = S180 <<< 1;
  localparam int               SHIFT = 28 - GCD_ANGLE_FRAC;

  function automatic logic signed [39:0] clamp40(input logic signed [39:0] v,
                                                 input logic signed [39:0] lim);
    return (v < -lim) ? -lim : ((v > lim) ? lim : v);
  endfunction

  logic signed [39:0] colat_a, colat_b, dl0, dl1, dl2, dl_abs;
  logic [39:0]        sh_a, sh_b, sh_d;
  logic               valid_r;
  gcd_item_t          item_r, item_nxt;

  always_comb begin
    colat_a = S90 - clamp40(40'(in_lat_a), S90);
    colat_b = S90 - clamp40(40'(in_lat_b), S90);
    dl0 = clamp40(40'(in_lon_a), S180) - clamp40(40'(in_lon_b), S180);
    dl1 = (dl0 > S180) ? dl0 - S360 : dl0;
    dl2 = (dl1 < -S180) ? dl1 + S360 : dl1;
    dl_abs = dl2[39] ? -dl2 : dl2;
    sh_a = colat_a << SHIFT;
    sh_b = colat_b << SHIFT;
    sh_d = dl_abs << SHIFT;
    item_nxt.colat_a = sh_a[GCD_MAG_W-1:0];
    item_nxt.colat_b = sh_b[GCD_MAG_W-1:0];
    item_nxt.dlon    = sh_d[GCD_MAG_W-1:0];
  end

  assign in_stall = valid_r && q_full;
  assign q_push   = valid_r && !q_full;
  assign q_item   = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item_r <= item_nxt;
    end
  end

endmodule

>>> rtl/gcd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_fifo: decoupling queue
// A short register queue between the front stage and the arithmetic pipe.
// ----------------------------------------------------------------------------
module gcd_fifo
  import gcd_pkg::*;
#(
  parameter int DEPTH = GCD_FIFO_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  gcd_item_t push_data,
  output logic      full,
  input  logic      pop,
  output gcd_item_t pop_data,
  output logic      empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  gcd_item_t          mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_r, rd_r;
  logic [CNT_W-1:0]   cnt_r;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (wr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= (rd_r == PTR_W'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH)) else $error("queue count above depth");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("push into a full queue");
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == CNT_W'($past(cnt_r) + 1'b1))
    else $error("queue count did not follow a push");

endmodule

>>> rtl/gcd_rot.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_rot: angle lane
// Degrees to Q30 radians, quadrant fold, then a pipelined CORDIC rotation.
// ----------------------------------------------------------------------------
module gcd_rot
  import gcd_pkg::*;
#(
  parameter int STAGES = GCD_CORDIC_STAGES
) (
  input  logic                         clk,
  input  logic                         adv,
  input  logic [GCD_MAG_W-1:0]         mag,
  output logic signed [GCD_TRIG_W-1:0] sin_o,
  output logic signed [GCD_TRIG_W-1:0] cos_o
);

  localparam int HALF_W = GCD_MAG_W / 2;
  localparam int PP_W   = HALF_W + 28;
  localparam int N_W    = GCD_D2R_N_W;
  localparam int NH_W   = N_W / 2;
  localparam int RP_W   = NH_W + 39;
  localparam int QS_W   = RP_W + NH_W;
  localparam logic [63:0] GAIN_EXTRA =
    (2 * STAGES < 64) ? ((GCD_GAIN_Q30 * 2 / 3) >> (2 * STAGES)) : 64'd0;
  localparam logic signed [GCD_TRIG_W-1:0] X_INIT =
    GCD_TRIG_W'(GCD_GAIN_Q30 + GAIN_EXTRA);

  logic [PP_W-1:0] pl_r, ph_r;
  logic [65:0]     d2_sum;
  logic [N_W-1:0]  n_r;
  logic [RP_W-1:0] rl_r, rh_r;
  logic [QS_W-1:0] q_sum;
  logic [31:0]     ang_r;

  logic signed [GCD_TRIG_W-1:0] x_r [STAGES+1];
  logic signed [GCD_TRIG_W-1:0] y_r [STAGES+1];
  logic signed [GCD_TRIG_W-1:0] z_r [STAGES+1];
  logic                         flip_r [STAGES+1];
  logic                         flip;

  // Product of the magnitude and pi in two halves.
  always_ff @(posedge clk) begin
    if (adv) begin
      pl_r <= PP_W'(mag[HALF_W-1:0]) * PP_W'(GCD_PI_Q26);
      ph_r <= PP_W'(mag[GCD_MAG_W-1:HALF_W]) * PP_W'(GCD_PI_Q26);
    end
  end

  assign d2_sum = 66'({ph_r, {HALF_W{1'b0}}}) + 66'(pl_r) + 66'(GCD_D2R_HALF);

  always_ff @(posedge clk) begin
    if (adv) begin
      n_r <= d2_sum[GCD_D2R_SHIFT +: N_W];
    end
  end

  // Division by the odd part of the divisor as a reciprocal product,
  // formed in two halves and summed on the next cycle.
  always_ff @(posedge clk) begin
    if (adv) begin
      rl_r <= RP_W'(n_r[NH_W-1:0]) * RP_W'(GCD_D2R_RECIP);
      rh_r <= RP_W'(n_r[N_W-1:NH_W]) * RP_W'(GCD_D2R_RECIP);
    end
  end

  assign q_sum = {rh_r, {NH_W{1'b0}}} + QS_W'(rl_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      ang_r <= q_sum[GCD_D2R_RSH +: 32];
    end
  end

  // Angles past a right angle rotate by pi minus the angle.
  assign flip = ang_r > GCD_HALF_PI_Q30;

  always_ff @(posedge clk) begin
    if (adv) begin
      x_r[0]    <= X_INIT;
      y_r[0]    <= '0;
      z_r[0]    <= GCD_TRIG_W'(flip ? GCD_PI_Q30 - ang_r : ang_r);
      flip_r[0] <= flip;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_cordic
    logic signed [GCD_TRIG_W-1:0] dx, dy;
    assign dx = y_r[i] >>> i;
    assign dy = x_r[i] >>> i;
    always_ff @(posedge clk) begin
      if (adv) begin
        flip_r[i+1] <= flip_r[i];
        if (!z_r[i][GCD_TRIG_W-1]) begin
          x_r[i+1] <= x_r[i] - dx;
          y_r[i+1] <= y_r[i] + dy;
          z_r[i+1] <= z_r[i] - GCD_TRIG_W'(GCD_ATAN_Q30[i]);
        end else begin
          x_r[i+1] <= x_r[i] + dx;
          y_r[i+1] <= y_r[i] - dy;
          z_r[i+1] <= z_r[i] + GCD_TRIG_W'(GCD_ATAN_Q30[i]);
        end
      end
    end
  end

  assign sin_o = y_r[STAGES];
  assign cos_o = flip_r[STAGES] ? -x_r[STAGES] : x_r[STAGES];

endmodule

>>> rtl/gcd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_back: arithmetic pipeline
// Law of cosines, square roots, CORDIC vectoring for the arc and scaling.
// ----------------------------------------------------------------------------
module gcd_back
  import gcd_pkg::*;
#(
  parameter int STAGES = GCD_CORDIC_STAGES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        item_valid,
  input  gcd_item_t   item,
  output logic        item_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [24:0] out_distance_m
);

  localparam int ISQ = GCD_ISQRT_STAGES;
  // rotation lanes, five combine steps, roots, product, vectoring, arc, scale
  localparam int LAT = GCD_ROT_PRE + STAGES + 5 + ISQ + 1 + STAGES + 2;
  localparam logic signed [71:0] ONE72 = 72'(GCD_ONE_Q60);

  function automatic logic [125:0] isq_step(input logic [62:0] n,
                                            input logic [62:0] res,
                                            input int          k);
    logic [62:0] pw, sum;
    pw  = 63'd1 << (2 * k);
    sum = res + pw;
    if (n >= sum) begin
      return {n - sum, (res >> 1) + pw};
    end
    return {n, res >> 1};
  endfunction

  logic adv;
  logic [LAT-1:0] vld_r;
  logic out_valid_r;
  logic [24:0] out_dist_r;

  logic signed [GCD_TRIG_W-1:0] s_a, c_a, s_b, c_b, s_d, c_d;

  logic signed [67:0] s12_r, c12_r, c12d_r;
  logic signed [GCD_TRIG_W-1:0] cd_r;
  logic signed [71:0] m_r, sum_r;
  logic signed [37:0] s12_sh;
  logic signed [61:0] cv_r;
  logic signed [63:0] n0_w, n1_w;

  logic [62:0] in0_r [ISQ+1];
  logic [62:0] rs0_r [ISQ+1];
  logic [62:0] in1_r [ISQ+1];
  logic [62:0] rs1_r [ISQ+1];
  logic        qneg_r [ISQ+1];
  logic [60:0] qax_r [ISQ+1];

  logic signed [65:0] vx_r [STAGES+1];
  logic signed [65:0] vy_r [STAGES+1];
  logic signed [GCD_TRIG_W-1:0] vz_r [STAGES+1];
  logic               vneg_r [STAGES+1];
  logic [61:0]        sn;

  logic signed [34:0] th_s;
  logic [31:0]        th_r;
  logic [54:0]        prod_r;
  logic [55:0]        rnd;

  assign adv      = !out_valid_r || !out_stall;
  assign item_pop = adv && item_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[LAT-2:0], item_valid};
      out_valid_r <= vld_r[LAT-1];
    end
  end

  gcd_rot #(.STAGES(STAGES)) u_rot_a (
    .clk(clk), .adv(adv), .mag(item.colat_a), .sin_o(s_a), .cos_o(c_a));
  gcd_rot #(.STAGES(STAGES)) u_rot_b (
    .clk(clk), .adv(adv), .mag(item.colat_b), .sin_o(s_b), .cos_o(c_b));
  gcd_rot #(.STAGES(STAGES)) u_rot_d (
    .clk(clk), .adv(adv), .mag(item.dlon), .sin_o(s_d), .cos_o(c_d));

  assign s12_sh = 38'(s12_r >>> 30);
  assign n0_w   = $signed(GCD_ONE_Q60) - 64'(cv_r);
  assign n1_w   = $signed(GCD_ONE_Q60) + 64'(cv_r);

  // cos c = sin a sin b cos d + cos a cos b, then the clamp and the roots' inputs.
  always_ff @(posedge clk) begin
    if (adv) begin
      s12_r  <= 68'(s_a) * 68'(s_b);
      c12_r  <= 68'(c_a) * 68'(c_b);
      cd_r   <= c_d;
      m_r    <= 72'(s12_sh) * 72'(cd_r);
      c12d_r <= c12_r;
      sum_r  <= m_r + 72'(c12d_r);
      if (sum_r > ONE72) begin
        cv_r <= 62'(ONE72);
      end else if (sum_r < -ONE72) begin
        cv_r <= 62'(-ONE72);
      end else begin
        cv_r <= 62'(sum_r);
      end
      in0_r[0]  <= n0_w[62:0];
      in1_r[0]  <= n1_w[62:0];
      rs0_r[0]  <= '0;
      rs1_r[0]  <= '0;
      qneg_r[0] <= cv_r[61];
      qax_r[0]  <= cv_r[61] ? 61'(-cv_r) : 61'(cv_r);
    end
  end

  for (genvar j = 0; j < ISQ; j++) begin : g_isqrt
    logic [125:0] st0, st1;
    assign st0 = isq_step(in0_r[j], rs0_r[j], ISQ - 1 - j);
    assign st1 = isq_step(in1_r[j], rs1_r[j], ISQ - 1 - j);
    always_ff @(posedge clk) begin
      if (adv) begin
        {in0_r[j+1], rs0_r[j+1]} <= st0;
        {in1_r[j+1], rs1_r[j+1]} <= st1;
        qneg_r[j+1] <= qneg_r[j];
        qax_r[j+1]  <= qax_r[j];
      end
    end
  end

  assign sn = 62'(rs0_r[ISQ][30:0]) * 62'(rs1_r[ISQ][30:0]);

  always_ff @(posedge clk) begin
    if (adv) begin
      vx_r[0]   <= 66'(qax_r[ISQ]);
      vy_r[0]   <= 66'(sn);
      vz_r[0]   <= '0;
      vneg_r[0] <= qneg_r[ISQ];
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_vec
    logic signed [65:0] dx, dy;
    assign dx = vy_r[i] >>> i;
    assign dy = vx_r[i] >>> i;
    always_ff @(posedge clk) begin
      if (adv) begin
        vneg_r[i+1] <= vneg_r[i];
        if (!vy_r[i][65]) begin
          vx_r[i+1] <= vx_r[i] + dx;
          vy_r[i+1] <= vy_r[i] - dy;
          vz_r[i+1] <= vz_r[i] + GCD_TRIG_W'(GCD_ATAN_Q30[i]);
        end else begin
          vx_r[i+1] <= vx_r[i] - dx;
          vy_r[i+1] <= vy_r[i] + dy;
          vz_r[i+1] <= vz_r[i] - GCD_TRIG_W'(GCD_ATAN_Q30[i]);
        end
      end
    end
  end

  // A negative cosine gives the supplement of the arc.
  assign th_s = vneg_r[STAGES] ? $signed({3'b000, GCD_PI_Q30}) - 35'(vz_r[STAGES])
                               : 35'(vz_r[STAGES]);
  assign rnd  = 56'(prod_r) + (56'd1 << 29);

  always_ff @(posedge clk) begin
    if (adv) begin
      if (th_s[34]) begin
        th_r <= '0;
      end else if (th_s > $signed({3'b000, GCD_PI_Q30})) begin
        th_r <= GCD_PI_Q30;
      end else begin
        th_r <= th_s[31:0];
      end
      prod_r <= 55'(th_r) * 55'(GCD_RADIUS_M);
      out_dist_r <= (rnd[55:30] > 26'(GCD_MAX_DIST)) ? GCD_MAX_DIST : rnd[54:30];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_distance_m = out_dist_r;

endmodule

>>> rtl/great_circle_distance.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// great_circle_distance: distance between two points on the Earth
// Spherical law of cosines on a 6371 km sphere, CORDIC trig, result in metres.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake         Word
//  in_      input      in_valid/stall    lat_a, lon_a, lat_b, lon_b (deg * 2^20)
//  out_     output     out_valid/stall   distance_m (whole metres, unsigned)
//
//  One word is taken every clock cycle while in_stall is low; each result
//  passes through the arithmetic pipeline, with one register per CORDIC
//  step and per square-root bit.
//  Reset clears only the valid flags and the queue pointers and count.
//  A stall on the result side while a result waits freezes the arithmetic
//  pipeline; the queue keeps taking words until it fills, and only then is
//  in_stall raised.
//
// The front stage clamps the coordinates to their legal ranges, forms both
// colatitudes and the longitude gap folded into [0, 180] degrees, and writes
// that word into the queue. The back pipeline converts the three angles to
// radians, runs three CORDIC rotation lanes for sines and cosines, combines
// them into the cosine of the arc, clamps it to [-1, 1], and recovers the arc
// by vectoring the pair (|c|, sqrt(1 - c^2)). The arc is scaled by the radius
// and rounded to whole metres.
// ----------------------------------------------------------------------------
module great_circle_distance
  import gcd_pkg::*;
#(
  parameter int CORDIC_STAGES = GCD_CORDIC_STAGES,
  parameter int FIFO_DEPTH    = GCD_FIFO_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [27:0] in_lat_a,
  input  logic signed [28:0] in_lon_a,
  input  logic signed [27:0] in_lat_b,
  input  logic signed [28:0] in_lon_b,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [24:0]        out_distance_m
);

  logic      q_push, q_full, q_pop, q_empty;
  gcd_item_t q_in, q_out;

  // Front stage: clamping and range folding.
  gcd_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_lat_a(in_lat_a), .in_lon_a(in_lon_a),
    .in_lat_b(in_lat_b), .in_lon_b(in_lon_b),
    .q_full(q_full), .q_push(q_push), .q_item(q_in)
  );

  // Queue that lets the front keep accepting while the back is stalled.
  gcd_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk(clk), .rst_n(rst_n),
    .push(q_push), .push_data(q_in), .full(q_full),
    .pop(q_pop), .pop_data(q_out), .empty(q_empty)
  );

  // Back pipeline: trigonometry, arc and scaling, with the output register.
  gcd_back #(.STAGES(CORDIC_STAGES)) u_back (
    .clk(clk), .rst_n(rst_n),
    .item_valid(!q_empty), .item(q_out), .item_pop(q_pop),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_distance_m(out_distance_m)
  );

  // The distance never exceeds half the circumference.
  a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_distance_m <= GCD_MAX_DIST)
    else $error("distance above half circumference");

endmodule

>>> tb/sv/tb_great_circle_distance.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_great_circle_distance: self-checking bench for the great-circle distance
// Drives coordinate words with random idle bursts on both channels, predicts
// each distance in fixed point and compares every result in arrival order.
// ----------------------------------------------------------------------------
module tb_great_circle_distance
  import gcd_pkg::*;
();

  localparam longint LAT_MAX   = 64'd90 << 20;
  localparam longint LON_MAX   = 64'd180 << 20;
  localparam longint ONE_Q60   = 64'sd1 << 60;
  localparam longint PI_Q30    = 64'(GCD_PI_Q30);
  localparam longint HALF_PI   = 64'(GCD_HALF_PI_Q30);
  localparam int     STAGES    = GCD_CORDIC_STAGES;
  localparam int     N_RANDOM  = 1650;
  localparam int     QUIET_AT  = 150;
  localparam int     DRAIN_CYC = 160;
  localparam int     LIMIT_CYC = 600000;

  typedef struct {
    logic signed [27:0] lat_a;
    logic signed [28:0] lon_a;
    logic signed [27:0] lat_b;
    logic signed [28:0] lon_b;
  } coord_word_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic signed [27:0] in_lat_a;
  logic signed [28:0] in_lon_a;
  logic signed [27:0] in_lat_b;
  logic signed [28:0] in_lon_b;
  logic               out_valid;
  logic               out_stall;
  logic [24:0]        out_distance_m;

  coord_word_t  pending_words[$];
  logic [24:0]  expected_dist[$];
  int           err_count;
  int           cycle_count;
  int           in_gap;
  int           out_gap;
  bit           quiet;

  great_circle_distance u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_lat_a      (in_lat_a),
    .in_lon_a      (in_lon_a),
    .in_lat_b      (in_lat_b),
    .in_lon_b      (in_lon_b),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_distance_m(out_distance_m)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Distance predictor.
  // ---------------------------------------------------------------------------

  function automatic longint clamp_s(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Floor integer square root, bit by bit from the top.
  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Degree magnitude with 20 fraction bits to radians in Q30, rounded.
  function automatic longint deg_mag_to_rad(longint mag);
    longint unsigned m28;
    longint unsigned div;
    m28 = 64'(mag) << 8;
    div = 64'd180 << 24;
    return longint'((m28 * 64'(GCD_PI_Q26) + div / 2) / div);
  endfunction

  // Rotation CORDIC for an angle in [0, pi]; above pi/2 it rotates by the
  // supplement and negates the cosine.
  function automatic void rotate_trig(input longint a, output longint s,
                                      output longint c);
    bit     flip;
    longint x, y, z, dx, dy;
    flip = (a > HALF_PI);
    x = 64'(GCD_GAIN_Q30);
    y = 0;
    z = flip ? PI_Q30 - a : a;
    if (2 * STAGES < 64) x = x + (((64'(GCD_GAIN_Q30) * 2) / 3) >>> (2 * STAGES));
    for (int i = 0; i < STAGES && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - 64'(GCD_ATAN_Q30[i]);
      end else begin
        x = x + dx; y = y - dy; z = z + 64'(GCD_ATAN_Q30[i]);
      end
    end
    s = y;
    c = flip ? -x : x;
  endfunction

  function automatic logic [24:0] predict_distance(coord_word_t w);
    longint la, oa, lb, ob, dl;
    longint s1, c1, s2, c2, sd, cd, cv, x, y, z, dx, dy, th;
    longint unsigned sn, dist_m;
    la = clamp_s(longint'(w.lat_a), -LAT_MAX, LAT_MAX);
    oa = clamp_s(longint'(w.lon_a), -LON_MAX, LON_MAX);
    lb = clamp_s(longint'(w.lat_b), -LAT_MAX, LAT_MAX);
    ob = clamp_s(longint'(w.lon_b), -LON_MAX, LON_MAX);
    // The longitude gap is folded into [0, 180] degrees; only its cosine counts.
    dl = oa - ob;
    if (dl > LON_MAX) dl = dl - 2 * LON_MAX;
    if (dl < -LON_MAX) dl = dl + 2 * LON_MAX;
    if (dl < 0) dl = -dl;
    rotate_trig(deg_mag_to_rad(LAT_MAX - la), s1, c1);
    rotate_trig(deg_mag_to_rad(LAT_MAX - lb), s2, c2);
    rotate_trig(deg_mag_to_rad(dl), sd, cd);
    // Law of cosines in Q60, then clamped so that the arc cosine is defined.
    cv = ((s1 * s2) >>> 30) * cd + c1 * c2;
    cv = clamp_s(cv, -ONE_Q60, ONE_Q60);
    sn = int_sqrt(64'(ONE_Q60 - cv)) * int_sqrt(64'(ONE_Q60 + cv));
    x = (cv < 0) ? -cv : cv;
    y = longint'(sn);
    z = 0;
    for (int i = 0; i < STAGES && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx; y = y - dy; z = z + 64'(GCD_ATAN_Q30[i]);
      end else begin
        x = x - dx; y = y + dy; z = z - 64'(GCD_ATAN_Q30[i]);
      end
    end
    th = (cv < 0) ? PI_Q30 - z : z;
    th = clamp_s(th, 0, PI_Q30);
    dist_m = (64'(th) * 64'd6371000 + (64'd1 << 29)) >> 30;
    if (dist_m > 64'(GCD_MAX_DIST)) dist_m = 64'(GCD_MAX_DIST);
    return dist_m[24:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  function automatic int rand_lat();
    return int'($urandom_range(0, 2 * 94371840)) - 94371840;
  endfunction

  function automatic int rand_lon();
    return int'($urandom_range(0, 2 * 188743680)) - 188743680;
  endfunction

  function automatic void push_word(longint la, longint oa, longint lb, longint ob);
    coord_word_t w;
    w.lat_a = la[27:0];
    w.lon_a = oa[28:0];
    w.lat_b = lb[27:0];
    w.lon_b = ob[28:0];
    pending_words = {pending_words, w};
  endfunction

  // Random word drawn from one of several shapes so that the whole span of
  // distances, the clamps and the rounding near zero and pi are all reached.
  function automatic void push_random_word();
    int kind;
    int la, oa;
    kind = $urandom_range(0, 9);
    la = rand_lat();
    oa = rand_lon();
    case (kind)
      0, 1, 2, 3: begin
        push_word(la, oa, rand_lat(), rand_lon());
      end
      4: begin
        // Raw bits over the whole port width, so every bit toggles and the
        // range clamps are hit often.
        push_word(longint'($signed(28'($urandom))), longint'($signed(29'($urandom))),
                  longint'($signed(28'($urandom))), longint'($signed(29'($urandom))));
      end
      5: begin
        // Nearby points: distance close to zero.
        push_word(la, oa, la + int'($urandom_range(0, 2000)) - 1000,
                  oa + int'($urandom_range(0, 2000)) - 1000);
      end
      6: begin
        // Near the antipode: cosine close to minus one.
        push_word(la, oa, -la + int'($urandom_range(0, 2000)) - 1000,
                  ((oa > 0) ? oa - 188743680 : oa + 188743680)
                  + int'($urandom_range(0, 2000)) - 1000);
      end
      7: begin
        // Longitudes straddling the date line, so the gap wraps.
        push_word(la, 188743680 - int'($urandom_range(0, 20000000)), rand_lat(),
                  -188743680 + int'($urandom_range(0, 20000000)));
      end
      8: begin
        // Points near the poles.
        push_word(94371840 - int'($urandom_range(0, 3000000)), oa,
                  ($urandom_range(0, 1) ? 1 : -1) * (94371840 - int'($urandom_range(0, 3000000))),
                  rand_lon());
      end
      default: begin
        // Same point exactly.
        push_word(la, oa, la, oa);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: presents the next pending word whenever the channel is free, and
  // inserts idle bursts between words until the closing stretch of the run.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else if (!in_valid || !in_stall) begin
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap   <= in_gap - 1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        in_valid <= 1'b0;
        in_gap   <= $urandom_range(1, 13) - 1;
      end else if (pending_words.size() > 0) begin
        in_valid <= 1'b1;
        in_lat_a <= pending_words[0].lat_a;
        in_lon_a <= pending_words[0].lon_a;
        in_lat_b <= pending_words[0].lat_b;
        in_lon_b <= pending_words[0].lon_b;
        void'(pending_words.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // The result side stalls in bursts of its own, also silent at the end.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_gap   <= 0;
    end else if (out_gap > 0) begin
      out_stall <= 1'b1;
      out_gap   <= out_gap - 1;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      out_stall <= 1'b1;
      out_gap   <= $urandom_range(1, 13) - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every accepted word yields one expected distance; every accepted
  // result is checked against the oldest one.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    coord_word_t w;
    logic [24:0] exp_d;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        w.lat_a = in_lat_a;
        w.lon_a = in_lon_a;
        w.lat_b = in_lat_b;
        w.lon_b = in_lon_b;
        expected_dist = {expected_dist, predict_distance(w)};
      end
      if (out_valid && !out_stall) begin
        if (expected_dist.size() == 0) begin
          $display("%0t: unexpected result distance_m=%0d", $time, out_distance_m);
          err_count++;
        end else begin
          exp_d = expected_dist.pop_front();
          if (out_distance_m !== exp_d) begin
            $display("%0t: distance_m mismatch expected=%0d actual=%0d",
                     $time, exp_d, out_distance_m);
            err_count++;
          end
        end
      end
    end
  end

  // Cycle limit: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYC) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) quiet <= (pending_words.size() < QUIET_AT);

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_lat_a    = '0;
    in_lon_a    = '0;
    in_lat_b    = '0;
    in_lon_b    = '0;
    out_stall   = 1'b0;
    in_gap      = 0;
    out_gap     = 0;
    quiet       = 1'b0;
    err_count   = 0;
    cycle_count = 0;

    // Directed words: range ends, clamps, zero distance, antipodes, wrap.
    push_word(0, 0, 0, 0);
    push_word(LAT_MAX, 0, -LAT_MAX, 0);
    push_word(LAT_MAX, LON_MAX, LAT_MAX, -LON_MAX);
    push_word(0, LON_MAX, 0, -LON_MAX);
    push_word(0, 0, 0, LON_MAX);
    push_word(0, -LON_MAX, 0, 0);
    push_word(-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX);
    push_word(-(64'sd1 << 27), -(64'sd1 << 28), (64'sd1 << 27) - 1, (64'sd1 << 28) - 1);
    push_word((64'sd1 << 27) - 1, (64'sd1 << 28) - 1, -(64'sd1 << 27), -(64'sd1 << 28));
    push_word(LAT_MAX + 1, LON_MAX + 1, -LAT_MAX - 1, -LON_MAX - 1);
    push_word(0, 179 << 20, 0, -(179 << 20));
    push_word(0, -(179 << 20), 0, 179 << 20);
    push_word(0, 90 << 20, 0, -(90 << 20));
    push_word(45 << 20, 10 << 20, -(45 << 20), -(170 << 20));
    push_word(0, 0, 0, 1);
    push_word(1, 0, 0, 0);
    push_word(LAT_MAX, 0, LAT_MAX - 1, 123 << 20);
    push_word(-LAT_MAX, 17 << 20, -LAT_MAX, -(99 << 20));
    push_word(30 << 20, 0, 60 << 20, 0);
    push_word(0, 0, 0, (90 << 20) + 1);
    push_word(-1, -1, -1, -1);
    for (int i = 0; i < N_RANDOM; i++) push_random_word();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_words.size() > 0 || in_valid) @(posedge clk);
    while (expected_dist.size() > 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
